// File: rtl/particle_pool_update_macros.svh
// ----------------------------------------------------------------------------
// particle_pool_update_macros
// Assertion macros for the particle pool.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, constants and helper functions shared by the particle pool logic.
// ----------------------------------------------------------------------------
package ppu_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int PTR_W      = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

	localparam int DIVD_W = 27;
	localparam int DIVS_W = 16;
	localparam int STEP_W = $clog2(DIVD_W + 1);

	localparam logic [15:0] LIFE_ONE   = 16'd32768;
	localparam logic [31:0] GRAVITY_Q8 = 32'd51200;
	localparam logic [17:0] SIZE_ONE   = 18'd131072;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
		logic [15:0]        life;
		logic [15:0]        max_life;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [15:0]        size;
	} entry_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic [15:0]        size;
	} result_t;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > 26'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -26'sd8388608)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(POOL_DEPTH - 1))
			r = '0;
		else
			r = p + 1'b1;
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(POOL_DEPTH))
			s = s - (CNT_W+1)'(POOL_DEPTH);
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [7:0] life_alpha(input logic [15:0] life);
		logic [8:0] a;
		a = life[15:7];
		return (a > 9'd255) ? 8'd255 : a[7:0];
	endfunction

endpackage

// File: rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update
// Ordered particle pool with a fixed-point Euler update on each tick.
// ----------------------------------------------------------------------------
// An add item is written at once while idle; busy stays low. A tick item walks
// the stored particles oldest first, each through memory read, load, the 27
// steps of the serial life divider and its done step, and write-back, then a
// closing flush state, on a pool of up to 64. The life divider dominates each
// particle's time. Results come one per surviving particle on valid for one
// cycle each, with last on the final one; the receiver cannot stall, and a
// tick on an empty pool gives no result.
module particle_pool_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [15:0]        time_step,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic [15:0]        life_span,
	input  logic [15:0]        start_size,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               valid,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_alpha,
	output logic [15:0]        out_size,
	output logic               last
);
	import ppu_pkg::*;

	`include "particle_pool_update_macros.svh"

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] oldest_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] kept_q;
	logic [PTR_W-1:0] rd_slot_q;
	logic [PTR_W-1:0] wr_slot_q;
	logic [15:0]      dt_q;

	entry_t           mem [POOL_DEPTH];
	entry_t           rd_q;
	logic             rd_en;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	entry_t           wr_data;

	logic signed [40:0] prod_x_s1;
	logic signed [40:0] prod_y_s1;
	logic [15:0]        grav_s1;
	logic [15:0]        size_s1;

	logic               div_start;
	logic               div_done;
	logic [DIVD_W-1:0]  quot;

	logic               accept;
	logic               full;
	logic [DIVD_W-1:0]  dec;
	logic [15:0]        life_new;
	logic               alive;
	entry_t             upd;
	result_t            upd_res;

	result_t pend_q;
	logic    pend_valid_q;
	result_t out_q;
	logic    valid_q;
	logic    last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(POOL_DEPTH));

	ppu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dt_q, 11'b0}),
		.divisor  (rd_q.max_life),
		.done     (div_done),
		.quotient (quot)
	);

	// Update arithmetic on the loaded entry.
	always_comb begin
		dec      = (dt_q == 16'd0) ? '0 : quot;
		life_new = (dec >= DIVD_W'(rd_q.life)) ? 16'd0 : rd_q.life - dec[15:0];
		alive    = (life_new != 16'd0);
		upd          = rd_q;
		upd.x        = sat24(26'(rd_q.x) + 26'($signed(prod_x_s1[40:16])));
		upd.y        = sat24(26'(rd_q.y) + 26'($signed(prod_y_s1[40:16])));
		upd.vy       = sat24(26'(rd_q.vy) + $signed({10'b0, grav_s1}));
		upd.life     = life_new;
		upd.size     = size_s1;
		upd_res.x     = upd.x;
		upd_res.y     = upd.y;
		upd_res.red   = rd_q.red;
		upd_res.green = rd_q.green;
		upd_res.blue  = rd_q.blue;
		upd_res.alpha = life_alpha(life_new);
		upd_res.size  = size_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = wr_slot_q;
		wr_data   = upd;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				wr_data.x        = pos_x;
				wr_data.y        = pos_y;
				wr_data.vx       = vel_x;
				wr_data.vy       = vel_y;
				wr_data.life     = LIFE_ONE;
				wr_data.max_life = life_span;
				wr_data.red      = red;
				wr_data.green    = green;
				wr_data.blue     = blue;
				wr_data.size     = start_size;
				wr_addr          = full ? oldest_q : ring_add(oldest_q, count_q);
				if (accept && op == OP_ADD)
					wr_en = 1'b1;
				if (accept && op == OP_TICK && count_q != '0)
					state_d = ST_READ;
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				wr_en   = alive;
				state_d = (idx_q + 1'b1 == count_q) ? ST_FLUSH : ST_READ;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_slot_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept)
			dt_q <= time_step;
		if (state_q == ST_LOAD) begin
			prod_x_s1 <= rd_q.vx * $signed({1'b0, dt_q});
			prod_y_s1 <= rd_q.vy * $signed({1'b0, dt_q});
			grav_s1   <= 16'((GRAVITY_Q8 * 32'(dt_q)) >> 16);
			size_s1   <= 16'((34'(rd_q.size) * 34'(SIZE_ONE - 18'(dt_q))) >> 17);
		end
		if (state_q == ST_UPDATE && alive)
			pend_q <= upd_res;
		if ((state_q == ST_UPDATE && alive && pend_valid_q) ||
			(state_q == ST_FLUSH && pend_valid_q))
			out_q <= pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			oldest_q     <= '0;
			idx_q        <= '0;
			kept_q       <= '0;
			rd_slot_q    <= '0;
			wr_slot_q    <= '0;
			pend_valid_q <= 1'b0;
			valid_q      <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_ADD) begin
						// Drop the oldest particle when full.
						if (full)
							oldest_q <= slot_inc(oldest_q);
						else
							count_q <= count_q + 1'b1;
					end
					if (accept && op == OP_TICK) begin
						idx_q        <= '0;
						kept_q       <= '0;
						rd_slot_q    <= oldest_q;
						wr_slot_q    <= oldest_q;
						pend_valid_q <= 1'b0;
					end
				end
				ST_UPDATE: begin
					idx_q     <= idx_q + 1'b1;
					rd_slot_q <= slot_inc(rd_slot_q);
					if (alive) begin
						wr_slot_q    <= slot_inc(wr_slot_q);
						kept_q       <= kept_q + 1'b1;
						pend_valid_q <= 1'b1;
						valid_q      <= pend_valid_q;
					end
				end
				ST_FLUSH: begin
					count_q      <= kept_q;
					valid_q      <= pend_valid_q;
					last_q       <= pend_valid_q;
					pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign valid     = valid_q;
	assign last      = last_q;
	assign out_x     = out_q.x;
	assign out_y     = out_q.y;
	assign out_red   = out_q.red;
	assign out_green = out_q.green;
	assign out_blue  = out_q.blue;
	assign out_alpha = out_q.alpha;
	assign out_size  = out_q.size;

	`PPU_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(POOL_DEPTH), "pool count overflow")
	`PPU_ASSERT_NOW(a_last_valid, last, valid, "last without a result")
	`PPU_ASSERT_NEXT(a_none_after_last, valid && last, !valid, "result after last")
	`PPU_ASSERT_NEXT(a_kept_bound, state_q == ST_UPDATE, kept_q <= idx_q, "kept exceeds walked")

endmodule

// File: rtl/ppu_divider.sv
// ----------------------------------------------------------------------------
// ppu_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppu_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ppu_pkg::DIVD_W-1:0]  dividend,
	input  logic [ppu_pkg::DIVS_W-1:0]  divisor,
	output logic                        done,
	output logic [ppu_pkg::DIVD_W-1:0]  quotient
);
	import ppu_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] num_q;
	logic [DIVD_W-1:0] quot_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, num_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(DIVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= dividend;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			num_q  <= {num_q[DIVD_W-2:0], 1'b0};
			quot_q <= {quot_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// File: verif/particle_pool_update_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_pool_update_test
// Self-checking bench for the particle pool: a queue-fed driver issues add
// and tick items with random gaps, a predictor keeps its own ordered pool and
// works out every particle a tick emits, and a monitor checks each strobed
// result field by field against the oldest expected particle.
// ----------------------------------------------------------------------------
module particle_pool_update_test;
	import ppu_pkg::*;

	typedef struct {
		logic               op;
		logic [15:0]        dt;
		logic signed [23:0] px, py, vx, vy;
		logic [15:0]        span, size;
		logic [7:0]         r, g, b;
		logic               hold;
	} item_t;

	typedef struct {
		result_t res;
		logic    last;
	} particle_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_ADD;
	logic [15:0]        time_step = '0;
	logic signed [23:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic [15:0]        life_span = 16'd1, start_size = '0;
	logic [7:0]         red = '0, green = '0, blue = '0;
	logic               valid;
	logic signed [23:0] out_x, out_y;
	logic [7:0]         out_red, out_green, out_blue, out_alpha;
	logic [15:0]        out_size;
	logic               last;

	item_t         pending[$];
	entry_t        pool[$];
	particle_out_t emitted_q[$];
	item_t         cur;
	int            gap_left = 0;
	int            errors = 0;
	int            n_adds = 0, n_ticks = 0, n_results = 0;

	particle_pool_update uut (.*);

	always #10 clk = ~clk;

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic void advance_pool(logic [15:0] dt);
		entry_t        e;
		entry_t        kept[$];
		particle_out_t o;
		longint        dec;
		longint        lf;
		foreach (pool[i]) begin
			e = pool[i];
			// old velocity moves the position; >>> on longint floors
			e.x = clamp24(longint'(pool[i].x) +
				((longint'(pool[i].vx) * longint'(dt)) >>> 16));
			e.y = clamp24(longint'(pool[i].y) +
				((longint'(pool[i].vy) * longint'(dt)) >>> 16));
			e.vy = clamp24(longint'(pool[i].vy) + ((longint'(51200) * longint'(dt)) >>> 16));
			if (e.max_life == 0)
				dec = (dt != 0) ? 64'd1 << 40 : 0;
			else
				dec = (longint'(dt) * 2048) / e.max_life;
			lf = e.life;
			e.life = (dec >= lf) ? 16'd0 : 16'(lf - dec);
			e.size = 16'((longint'(e.size) * (131072 - longint'(dt))) >> 17);
			if (e.life != 0)
				kept = {kept, e};
		end
		pool = kept;
		foreach (pool[i]) begin
			o.res.x = pool[i].x;
			o.res.y = pool[i].y;
			o.res.red = pool[i].red;
			o.res.green = pool[i].green;
			o.res.blue = pool[i].blue;
			o.res.alpha = (pool[i].life >> 7) > 255 ? 8'd255 : 8'(pool[i].life >> 7);
			o.res.size = pool[i].size;
			o.last = (i == pool.size() - 1);
			emitted_q = {emitted_q, o};
		end
	endfunction

	function automatic void apply_item(item_t it);
		entry_t e;
		if (it.op == OP_ADD) begin
			if (pool.size() >= POOL_DEPTH)
				void'(pool.pop_front());
			e.x = it.px; e.y = it.py; e.vx = it.vx; e.vy = it.vy;
			e.life = 16'd32768; e.max_life = it.span;
			e.red = it.r; e.green = it.g; e.blue = it.b; e.size = it.size;
			pool = {pool, e};
			n_adds++;
		end else begin
			advance_pool(it.dt);
			n_ticks++;
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch @%0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// driver: hold start until the item is taken, then wait a drawn gap
	always @(posedge clk) begin
		logic presenting;
		presenting = start;
		if (arst_n) begin
			if (start && !busy) begin
				apply_item(cur);
				presenting = 1'b0;
				gap_left = $urandom_range(0, 12);
			end
			if (!presenting) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending.size() > 0 && (!pending[0].hold ||
						(emitted_q.size() == 0 && !busy))) begin
					cur = pending.pop_front();
					op <= cur.op; time_step <= cur.dt;
					pos_x <= cur.px; pos_y <= cur.py; vel_x <= cur.vx; vel_y <= cur.vy;
					life_span <= cur.span; start_size <= cur.size;
					red <= cur.r; green <= cur.g; blue <= cur.b;
					presenting = 1'b1;
				end
			end
		end
		start <= presenting;
	end

	always @(posedge clk) begin
		particle_out_t w;
		if (arst_n && valid) begin
			n_results++;
			if (emitted_q.size() == 0)
				report("unexpected result", out_x, 0);
			else begin
				w = emitted_q.pop_front();
				if (out_x != w.res.x) report("out_x", out_x, w.res.x);
				if (out_y != w.res.y) report("out_y", out_y, w.res.y);
				if (out_red != w.res.red) report("out_red", out_red, w.res.red);
				if (out_green != w.res.green) report("out_green", out_green, w.res.green);
				if (out_blue != w.res.blue) report("out_blue", out_blue, w.res.blue);
				if (out_alpha != w.res.alpha) report("out_alpha", out_alpha, w.res.alpha);
				if (out_size != w.res.size) report("out_size", out_size, w.res.size);
				if (last != w.last) report("last", last, w.last);
			end
		end
	end

	function automatic void queue_add(logic signed [23:0] px, py, vx, vy,
		logic [15:0] span, size, logic [7:0] r, g, b);
		item_t it;
		it = '{OP_ADD, 16'($urandom), px, py, vx, vy, span, size, r, g, b, 1'b0};
		pending = {pending, it};
	endfunction

	function automatic void queue_random_add(logic [15:0] span);
		queue_add(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), span,
			16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	function automatic void queue_tick(logic [15:0] dt, logic hold);
		item_t it;
		it = '{OP_TICK, dt, 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), hold};
		pending = {pending, it};
	endfunction

	initial begin
		int made;
		int burst;
		bit filled;
		filled = 1'b0;
		// tick on an empty pool gives nothing
		queue_tick(16'd1000, 1'b0);
		queue_add(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF, 8'h00, 8'hFF);
		queue_add(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'd1,
			16'h0000, 8'h00, 8'hFF, 8'h00);
		queue_add(24'sd0, 24'sd0, 24'sd256, -24'sd256, 16'd0, 16'h0100, 8'h80, 8'h40,
			8'h20);
		queue_add(-24'sd1, 24'sd1, -24'sd1, 24'sd1, 16'd4096, 16'h8000, 8'h01, 8'h02,
			8'h03);
		// zero step: nothing moves, all emitted
		queue_tick(16'd0, 1'b1);
		queue_tick(16'd1, 1'b0);
		queue_tick(16'hFFFF, 1'b0);
		queue_add(24'sd1000, 24'sd2000, 24'sd300, -24'sd400, 16'hFFFF, 16'hFFFF,
			8'hAA, 8'h55, 8'hCC);
		queue_tick(16'hFFFF, 1'b0);
		queue_tick(16'd0, 1'b0);
		made = 0;
		while (made < 230) begin
			if (made >= 40 && !filled) begin
				// overflow the pool so the oldest ones get overwritten
				for (int i = 0; i < 70; i++)
					queue_random_add($urandom_range(0, 3) == 0 ? 16'($urandom) :
						16'($urandom_range(8192, 65535)));
				queue_tick(16'($urandom_range(0, 2000)), 1'b1);
				made += 71;
				filled = 1'b1;
			end
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst; i++) begin
				case ($urandom_range(0, 3))
					0: queue_random_add(16'($urandom_range(1, 4096)));
					1: queue_random_add(16'($urandom_range(0, 15)));
					default: queue_random_add(16'($urandom));
				endcase
			end
			queue_tick($urandom_range(0, 5) == 0 ? 16'($urandom) :
				16'($urandom_range(0, 3000)), $urandom_range(0, 9) == 0);
			made += burst + 1;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && !start);
		wait (emitted_q.size() == 0 && !busy);
		repeat (2100) @(posedge clk);
		$display("ran %0d adds and %0d ticks, %0d particles checked", n_adds, n_ticks,
			n_results);
		$display("covered empty-pool ticks, zero and full-scale steps, pool overflow");
		if (errors == 0 && emitted_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
